### rtl/core/sosp_pkg.sv
package sosp_pkg;

   localparam int NUM_SUBSTACKS_DEFAULT  = 8;
   localparam int SUBSTACK_DEPTH_DEFAULT = 128;

   localparam int DATA_W  = 32;
   localparam int LIMIT_W = 8;
   localparam int COUNT_W = 4;
   localparam int INDEX_W = 3;
   localparam int CSR_W   = 8;

   localparam logic [7:0] LIMIT_RESET = 8'd128;
   localparam logic [3:0] COUNT_RESET = 4'd8;

   typedef enum logic [0:0] {
      CSR_SUBSTACK_LIMIT   = 1'b0,
      CSR_SUBSTACKS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_POP_AT = 2'd2,
      FUNC_TOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_SELECT,
      ACT_SCAN,
      ACT_PUSH_ADV,
      ACT_PUSH_WR,
      ACT_POP,
      ACT_CAPTURE,
      ACT_RESPOND
   } action_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_IS_PUSH,
      COND_SCAN_MORE
   } cond_type;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SELECT   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_POP      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CAPTURE  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_PUSH_ADV = 4'd6;
   localparam logic [STEP_W-1:0] STEP_PUSH_WR  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd8;

   typedef struct packed {
      action_type          action;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ucode_word_type;

   function automatic ucode_word_type sosp_ucode(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      unique case (step)
         STEP_IDLE:     w = '{ACT_LOAD,     COND_NO_START,  STEP_IDLE};
         STEP_DISPATCH: w = '{ACT_NONE,     COND_IS_PUSH,   STEP_PUSH_ADV};
         STEP_SELECT:   w = '{ACT_SELECT,   COND_NEVER,     STEP_IDLE};
         STEP_SCAN:     w = '{ACT_SCAN,     COND_SCAN_MORE, STEP_SCAN};
         STEP_POP:      w = '{ACT_POP,      COND_NEVER,     STEP_IDLE};
         STEP_CAPTURE:  w = '{ACT_CAPTURE,  COND_ALWAYS,    STEP_FINISH};
         STEP_PUSH_ADV: w = '{ACT_PUSH_ADV, COND_NEVER,     STEP_IDLE};
         STEP_PUSH_WR:  w = '{ACT_PUSH_WR,  COND_NEVER,     STEP_IDLE};
         STEP_FINISH:   w = '{ACT_RESPOND,  COND_ALWAYS,    STEP_IDLE};
         default:       w = '{ACT_NONE,     COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/set_of_stacks_with_pop_at.sv
// One logical stack built from NUM_SUBSTACKS bounded substacks held in a single-port
// element memory. A request is taken when start is high and busy is low; its result
// appears one cycle on the rsp_ ports with rsp_valid high and cannot be held off.
// A push runs the dispatch, push-advance, push-write and finish steps of the control
// program; pop, read-top and pop-at run the dispatch, select, scan, pop, capture and
// finish steps, the scan step stepping over empty substacks one per cycle. Configuration
// writes are applied at once and should only be made while busy is low.
module set_of_stacks_with_pop_at
   import sosp_pkg::*;
#(
   parameter int NUM_SUBSTACKS  = NUM_SUBSTACKS_DEFAULT,
   parameter int SUBSTACK_DEPTH = SUBSTACK_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_func,
   input  logic signed [DATA_W-1:0]  req_push_value,
   input  logic [INDEX_W-1:0]        req_substack_index,
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_value,
   output logic                      rsp_value_valid,
   output logic                      rsp_is_empty,
   output logic                      rsp_is_full,
   output logic [1:0]                rsp_error,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   localparam int FW    = $clog2(SUBSTACK_DEPTH + 1);
   localparam int SW    = $clog2(NUM_SUBSTACKS);
   localparam int NW    = $clog2(NUM_SUBSTACKS + 1);
   localparam int ENTRY = NUM_SUBSTACKS * SUBSTACK_DEPTH;
   localparam int AW    = $clog2(ENTRY);
   localparam int LCW   = (FW > LIMIT_W) ? FW : LIMIT_W;
   localparam int NCW   = (NW > COUNT_W) ? NW : COUNT_W;

   // control
   logic [STEP_W-1:0]  step_ff, step_in;
   ucode_word_type     uword;
   logic               cond_true;

   // configuration
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FW-1:0]      lim;
   logic [NW-1:0]      cnt;

   // datapath state
   logic [FW-1:0]      fill_ff [NUM_SUBSTACKS];
   logic [FW-1:0]      fill_in [NUM_SUBSTACKS];
   logic [SW-1:0]      cur_ff, cur_in;
   logic [SW-1:0]      s_ff, s_in;
   func_type           func_ff, func_in;
   logic [DATA_W-1:0]  push_ff, push_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic               vvalid_ff, vvalid_in;
   err_type            err_ff, err_in;

   // element memory
   logic [DATA_W-1:0]  elem_store_ff [ENTRY];
   logic [DATA_W-1:0]  rd_data_ff;
   logic [AW-1:0]      mem_addr;
   logic [FW-1:0]      mem_pos;
   logic               mem_we;

   // response
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_vvalid_ff, rsp_vvalid_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_full_ff, rsp_full_in;
   err_type            rsp_err_ff, rsp_err_in;

   logic               accept;
   logic               any_filled;
   logic [FW-1:0]      fill_s;

   assign busy   = (step_ff != STEP_IDLE);
   assign accept = start && !busy;
   assign uword  = sosp_ucode(step_ff);
   assign fill_s = fill_ff[s_ff];

   // effective limit and substack count
   always_comb begin
      if (limit_ff == '0) begin
         lim = FW'(1);
      end else if (LCW'(limit_ff) > LCW'(SUBSTACK_DEPTH)) begin
         lim = FW'(SUBSTACK_DEPTH);
      end else begin
         lim = FW'(limit_ff);
      end
      if (count_ff == '0) begin
         cnt = NW'(1);
      end else if (NCW'(count_ff) > NCW'(NUM_SUBSTACKS)) begin
         cnt = NW'(NUM_SUBSTACKS);
      end else begin
         cnt = NW'(count_ff);
      end
   end

   // sequencer: jump on condition, else step on
   always_comb begin
      unique case (uword.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_START:  cond_true = !start;
         COND_IS_PUSH:   cond_true = (func_ff == FUNC_PUSH);
         COND_SCAN_MORE: cond_true = (s_ff != '0) && (fill_s == '0);
         default:        cond_true = 1'b1;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      any_filled = 1'b0;
      for (int i = 0; i < NUM_SUBSTACKS; i++) begin
         if (fill_ff[i] != '0) begin
            any_filled = 1'b1;
         end
      end
   end

   always_comb begin
      if (uword.action == ACT_PUSH_WR) begin
         mem_pos = fill_s;
      end else begin
         mem_pos = fill_s - FW'(1);
      end
      mem_addr = AW'(s_ff) * AW'(SUBSTACK_DEPTH) + AW'(mem_pos);
   end

   // datapath, driven by the control word
   always_comb begin
      limit_in      = limit_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      s_in          = s_ff;
      func_in       = func_ff;
      push_in       = push_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      vvalid_in     = vvalid_ff;
      err_in        = err_ff;
      mem_we        = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_err_in    = rsp_err_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SUBSTACK_LIMIT:   limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_SUBSTACKS_IN_USE: count_in = csr_wdata[COUNT_W-1:0];
            default:              limit_in = limit_ff;
         endcase
      end

      unique case (uword.action)
         ACT_LOAD: begin
            if (accept) begin
               func_in   = func_type'(req_func);
               push_in   = req_push_value;
               idx_in    = req_substack_index;
               s_in      = cur_ff;
               val_in    = '0;
               vvalid_in = 1'b0;
               err_in    = ERR_NONE;
            end
         end
         ACT_SELECT: begin
            if (func_ff == FUNC_POP_AT) begin
               if (int'(idx_ff) > NUM_SUBSTACKS - 1) begin
                  s_in = SW'(NUM_SUBSTACKS - 1);
               end else begin
                  s_in = SW'(idx_ff);
               end
            end else begin
               s_in = cur_ff;
            end
         end
         ACT_SCAN: begin
            if ((s_ff != '0) && (fill_s == '0)) begin
               s_in = s_ff - SW'(1);
            end
         end
         ACT_PUSH_ADV: begin
            if (NW'(s_ff) >= cnt) begin
               err_in = ERR_OVERFLOW;
            end else if (fill_s >= lim) begin
               if (NW'(s_ff) + NW'(1) < cnt) begin
                  s_in   = s_ff + SW'(1);
                  cur_in = s_ff + SW'(1);
               end else begin
                  err_in = ERR_OVERFLOW;
               end
            end
         end
         ACT_PUSH_WR: begin
            if ((err_ff == ERR_NONE) && (fill_s < lim)) begin
               mem_we        = 1'b1;
               fill_in[s_ff] = fill_s + FW'(1);
            end
         end
         ACT_POP: begin
            if (func_ff != FUNC_POP_AT) begin
               cur_in = s_ff;
            end
            if (fill_s == '0) begin
               err_in = ERR_UNDERFLOW;
            end else begin
               vvalid_in = 1'b1;
               if (func_ff != FUNC_TOP) begin
                  fill_in[s_ff] = fill_s - FW'(1);
               end
            end
         end
         ACT_CAPTURE: begin
            if (vvalid_ff) begin
               val_in = rd_data_ff;
            end
         end
         ACT_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = val_ff;
            rsp_vvalid_in = vvalid_ff;
            rsp_empty_in  = !any_filled;
            rsp_full_in   = (fill_ff[SW'(cnt - NW'(1))] >= lim);
            rsp_err_in    = err_ff;
         end
         default: begin
            s_in = s_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         limit_ff     <= LIMIT_RESET;
         count_ff     <= COUNT_RESET;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SUBSTACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      func_ff       <= func_in;
      push_ff       <= push_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      vvalid_ff     <= vvalid_in;
      err_ff        <= err_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_err_ff    <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         elem_store_ff[mem_addr] <= push_ff;
      end
      rd_data_ff <= elem_store_ff[mem_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_value_valid = rsp_vvalid_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_error       = rsp_err_ff;

   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (step_ff == STEP_IDLE))
      else $error("response strobe outside idle step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not make the block busy");

   a_value_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vvalid_ff) |-> (rsp_err_ff == ERR_NONE))
      else $error("element returned together with an error");

   a_scan_down: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == STEP_SCAN) && ($past(step_ff) == STEP_SCAN)) |-> (s_ff <= $past(s_ff)))
      else $error("scan moved upward");

   a_write_step: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((step_ff == STEP_PUSH_WR) && (func_ff == FUNC_PUSH)))
      else $error("element write outside push");

endmodule

### tb/sv/set_of_stacks_with_pop_at_checker.sv
`timescale 1ns / 100ps

module set_of_stacks_with_pop_at_checker
   import sosp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_func,
   input  logic [DATA_W-1:0]  req_push_value,
   input  logic [INDEX_W-1:0] req_substack_index,
   input  logic               rsp_valid,
   input  logic [DATA_W-1:0]  rsp_value,
   input  logic               rsp_value_valid,
   input  logic               rsp_is_empty,
   input  logic               rsp_is_full,
   input  logic [1:0]         rsp_error,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 mismatch_count,
   output int                 results_outstanding
);

   localparam int NSUB  = NUM_SUBSTACKS_DEFAULT;
   localparam int DEPTH = SUBSTACK_DEPTH_DEFAULT;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              value_valid;
      logic              is_empty;
      logic              is_full;
      err_type           error;
   } outcome_type;

   outcome_type       expected_outcomes[$];
   logic [DATA_W-1:0] element_mem[NSUB][DEPTH];
   int                fill[NSUB];
   int                cur_substack;
   logic [LIMIT_W-1:0] limit_reg;
   logic [COUNT_W-1:0] count_reg;

   initial begin
      mismatch_count = 0;
      results_outstanding = 0;
   end

   function automatic outcome_type stack_outcome(func_type f, logic [DATA_W-1:0] v,
                                                 logic [INDEX_W-1:0] ix);
      outcome_type o;
      int lim;
      int cnt;
      int s;
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      cnt = int'(count_reg);
      if (cnt < 1) cnt = 1;
      if (cnt > NSUB) cnt = NSUB;
      o.value = '0;
      o.value_valid = 1'b0;
      o.is_empty = 1'b1;
      o.is_full = 1'b0;
      o.error = ERR_NONE;
      if (f == FUNC_PUSH) begin
         s = cur_substack;
         if (s >= cnt) begin
            o.error = ERR_OVERFLOW;
         end else begin
            if (fill[s] >= lim) begin
               if (s + 1 < cnt) begin
                  s++;
                  cur_substack = s;
               end else begin
                  o.error = ERR_OVERFLOW;
               end
            end
            if (o.error == ERR_NONE && fill[s] < lim) begin
               element_mem[s][fill[s]] = v;
               fill[s]++;
            end
         end
      end else begin
         s = (f == FUNC_POP_AT) ? int'(ix) : cur_substack;
         while (s > 0 && fill[s] == 0) s--;
         if (f != FUNC_POP_AT) cur_substack = s;
         if (fill[s] == 0) begin
            o.error = ERR_UNDERFLOW;
         end else begin
            o.value = element_mem[s][fill[s] - 1];
            o.value_valid = 1'b1;
            if (f != FUNC_TOP) fill[s]--;
         end
      end
      foreach (fill[i]) if (fill[i] != 0) o.is_empty = 1'b0;
      o.is_full = (fill[cnt - 1] >= lim);
      return o;
   endfunction

   function automatic int field_differs(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (fill[i]) fill[i] = 0;
         cur_substack = 0;
         limit_reg = LIMIT_RESET;
         count_reg = COUNT_RESET;
         expected_outcomes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SUBSTACK_LIMIT:   limit_reg = csr_wdata[LIMIT_W-1:0];
               CSR_SUBSTACKS_IN_USE: count_reg = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result, expected none actual value %0h error %0d",
                        $time, rsp_value, rsp_error);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               mismatch_count += field_differs("value", want.value, rsp_value);
               mismatch_count += field_differs("value_valid", want.value_valid,
                                               rsp_value_valid);
               mismatch_count += field_differs("is_empty", want.is_empty, rsp_is_empty);
               mismatch_count += field_differs("is_full", want.is_full, rsp_is_full);
               mismatch_count += field_differs("error", want.error, rsp_error);
            end
         end
         if (start && !busy)
            expected_outcomes.push_back(stack_outcome(func_type'(req_func), req_push_value,
                                                      req_substack_index));
      end
      results_outstanding = expected_outcomes.size();
   end

endmodule

### tb/sv/set_of_stacks_with_pop_at_tb.sv
`timescale 1ns / 100ps

module set_of_stacks_with_pop_at_tb;
   import sosp_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES      = 14;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_func = FUNC_PUSH;
   logic [DATA_W-1:0]   req_push_value = '0;
   logic [INDEX_W-1:0]  req_substack_index = '0;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_value;
   logic                rsp_value_valid;
   logic                rsp_is_empty;
   logic                rsp_is_full;
   logic [1:0]          rsp_error;
   logic                csr_we = 1'b0;
   logic [0:0]          csr_index = CSR_SUBSTACK_LIMIT;
   logic [CSR_W-1:0]    csr_wdata = '0;
   int                  mismatch_count;
   int                  results_outstanding;
   int                  cycles = 0;
   bit                  idling_on = 1'b1;

   set_of_stacks_with_pop_at DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_push_value(req_push_value),
      .req_substack_index(req_substack_index),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_value_valid(rsp_value_valid),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .rsp_error(rsp_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   set_of_stacks_with_pop_at_checker stack_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_push_value(req_push_value),
      .req_substack_index(req_substack_index),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_value_valid(rsp_value_valid),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .rsp_error(rsp_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .results_outstanding(results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("set_of_stacks_with_pop_at_tb failed");
            $finish;
         end
      end
   end

   task automatic issue_request(func_type f, logic [DATA_W-1:0] v, logic [INDEX_W-1:0] ix);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 99) < 9) begin
         gap = $urandom_range(1, 20);
         start <= 1'b0;
         req_push_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_push_value <= v;
      req_substack_index <= ix;
      do @(posedge clock); while (busy);
   endtask

   // block idle with every request answered
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (results_outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_request(int push_pct);
      func_type f;
      logic [DATA_W-1:0] v;
      if ($urandom_range(0, 99) < push_pct) begin
         f = FUNC_PUSH;
      end else begin
         case ($urandom_range(0, 2))
            0: f = FUNC_POP;
            1: f = FUNC_POP_AT;
            default: f = FUNC_TOP;
         endcase
      end
      case ($urandom_range(0, 15))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         default: v = $urandom;
      endcase
      issue_request(f, v, INDEX_W'($urandom_range(0, 7)));
   endtask

   initial begin
      int n;
      logic [CSR_W-1:0] lim;
      logic [CSR_W-1:0] cnt;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // empty set at reset settings
      issue_request(FUNC_POP, '0, '0);
      issue_request(FUNC_TOP, '0, '0);
      issue_request(FUNC_POP_AT, '0, 3'd7);
      issue_request(FUNC_PUSH, 32'h7fff_ffff, '0);
      issue_request(FUNC_PUSH, 32'h8000_0000, '0);
      issue_request(FUNC_PUSH, 32'h0000_0000, '0);
      issue_request(FUNC_PUSH, 32'hffff_ffff, '0);
      issue_request(FUNC_TOP, '0, '0);
      issue_request(FUNC_POP_AT, '0, 3'd5);
      issue_request(FUNC_POP, '0, '0);

      // limit clamps to one, lowered below fill count
      settle();
      write_reg(CSR_SUBSTACK_LIMIT, 8'd0);
      write_reg(CSR_SUBSTACKS_IN_USE, 8'd2);
      issue_request(FUNC_PUSH, 32'haaaa_5555, '0);
      issue_request(FUNC_PUSH, 32'h1234_5678, '0);
      issue_request(FUNC_POP_AT, '0, 3'd0);
      issue_request(FUNC_POP, '0, '0);
      issue_request(FUNC_TOP, '0, '0);
      issue_request(FUNC_PUSH, 32'h5555_aaaa, '0);

      // current substack beyond the ones in use
      settle();
      write_reg(CSR_SUBSTACKS_IN_USE, 8'd0);
      issue_request(FUNC_PUSH, 32'h0f0f_0f0f, '0);
      issue_request(FUNC_POP_AT, '0, 3'd3);

      settle();
      write_reg(CSR_SUBSTACK_LIMIT, 8'd255);
      write_reg(CSR_SUBSTACKS_IN_USE, 8'd15);
      issue_request(FUNC_POP, '0, '0);
      issue_request(FUNC_POP, '0, '0);
      issue_request(FUNC_PUSH, 32'hdead_beef, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            lim = 8'd1;
            cnt = 8'd8;
         end else if (p == 1) begin
            lim = 8'd128;
            cnt = 8'd1;
         end else begin
            case ($urandom_range(0, 5))
               0: lim = 8'd0;
               1: lim = 8'd1;
               2: lim = CSR_W'($urandom_range(2, 6));
               3: lim = 8'd128;
               4: lim = 8'd255;
               default: lim = CSR_W'($urandom_range(7, 127));
            endcase
            case ($urandom_range(0, 4))
               0: cnt = 8'd0;
               1: cnt = 8'd1;
               2: cnt = CSR_W'($urandom_range(2, 7));
               3: cnt = 8'd8;
               default: cnt = CSR_W'($urandom_range(9, 15));
            endcase
         end
         settle();
         write_reg(CSR_SUBSTACK_LIMIT, lim);
         write_reg(CSR_SUBSTACKS_IN_USE, cnt);
         idling_on = (p != 3);
         n = (p == 1) ? 200 : $urandom_range(100, 165);
         for (int i = 0; i < n; i++)
            random_request((i < n * 2 / 3) ? 75 : 20);
      end

      settle();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("set_of_stacks_with_pop_at_tb passed");
      end else begin
         $display("set_of_stacks_with_pop_at_tb failed");
      end
      $finish;
   end

endmodule
